FILE: rtl/stsc_pkg.sv
package stsc_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int LINE_BITS   = 20;

  localparam logic [6:0] K_END    = 7'd0;
  localparam logic [6:0] K_WILD   = 7'd1;
  localparam logic [6:0] K_DOT    = 7'd41;
  localparam logic [6:0] K_IDENT  = 7'd47;
  localparam logic [6:0] K_KW0    = 7'd48;
  localparam logic [6:0] K_INT    = 7'd91;
  localparam logic [6:0] K_FLOAT  = 7'd92;
  localparam logic [6:0] K_CHAR   = 7'd93;
  localparam logic [6:0] K_STRING = 7'd94;
  localparam logic [6:0] K_ERROR  = 7'd95;

  localparam int KW_COUNT = 43;
  localparam int KW_MAX   = 9;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_req;
  } in_item_t;

  typedef struct packed {
    logic [6:0]             kind;
    logic [OFFSET_BITS-1:0] tok_offset;
    logic [15:0]            length;
    logic [LINE_BITS-1:0]   line;
    logic [15:0]            column;
    logic                   last;
  } out_item_t;

  // up to three tokens caused by one input item
  typedef struct packed {
    logic [1:0]            count;
    out_item_t [2:0]       tok;
  } bundle_t;

  // keyword text, right aligned, first letter in the highest used byte
  localparam logic [8*KW_MAX-1:0] KW_TXT [KW_COUNT] = '{
    72'("any"), 72'("await"), 72'("async"), 72'("bool"), 72'("break"), 72'("case"),
    72'("const"), 72'("continue"), 72'("component"), 72'("else"), 72'("enum"),
    72'("exclusive"), 72'("false"), 72'("float"), 72'("flow"), 72'("for"),
    72'("func"), 72'("if"), 72'("impl"), 72'("int"), 72'("interface"), 72'("kits"),
    72'("loop"), 72'("match"), 72'("module"), 72'("nil"), 72'("nock"), 72'("read"),
    72'("return"), 72'("set"), 72'("string"), 72'("struct"), 72'("system"),
    72'("tag"), 72'("target"), 72'("taggroup"), 72'("true"), 72'("type"),
    72'("unset"), 72'("var"), 72'("void"), 72'("with"), 72'("write")
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd5, 4'd4, 4'd5, 4'd4, 4'd5, 4'd8, 4'd9, 4'd4, 4'd4, 4'd9, 4'd5,
    4'd5, 4'd4, 4'd3, 4'd4, 4'd2, 4'd4, 4'd3, 4'd9, 4'd4, 4'd4, 4'd5, 4'd6, 4'd3,
    4'd4, 4'd4, 4'd6, 4'd3, 4'd6, 4'd6, 4'd6, 4'd3, 4'd6, 4'd8, 4'd4, 4'd4, 4'd5,
    4'd3, 4'd4, 4'd4, 4'd5
  };

  function automatic logic [6:0] word_kind(input logic [3:0] len,
                                           input logic [8*KW_MAX-1:0] w);
    logic [6:0]          k;
    logic [8*KW_MAX-1:0] mask;
    k    = K_IDENT;
    mask = (72'(1) << (8 * len)) - 72'(1);
    if (len == 4'd1 && w[7:0] == 8'h5F) begin
      k = K_WILD;
    end else if (len <= 4'(KW_MAX)) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        if (len == KW_LEN[i] && (w & mask) == KW_TXT[i]) k = 7'(K_KW0 + 7'(i));
      end
    end
    return k;
  endfunction

endpackage

FILE: rtl/stsc_front.sv
module stsc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  stsc_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              push,
  output stsc_pkg::bundle_t push_data
);
  import stsc_pkg::*;

  localparam logic [3:0] M_IDLE       = 4'd0;
  localparam logic [3:0] M_LINECOM    = 4'd1;
  localparam logic [3:0] M_BLOCK      = 4'd2;
  localparam logic [3:0] M_BLOCK_STAR = 4'd3;
  localparam logic [3:0] M_IDENT      = 4'd4;
  localparam logic [3:0] M_NUM        = 4'd5;
  localparam logic [3:0] M_NUM_DOT    = 4'd6;
  localparam logic [3:0] M_FRAC       = 4'd7;
  localparam logic [3:0] M_OP         = 4'd8;
  localparam logic [3:0] M_STR        = 4'd9;
  localparam logic [3:0] M_CHAR0      = 4'd10;
  localparam logic [3:0] M_CHAR1      = 4'd11;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

  logic [3:0]             mode, mode_next;
  logic [OFFSET_BITS-1:0] tstart, tstart_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [LINE_BITS-1:0]   lcnt, lcnt_next;
  logic [OFFSET_BITS-1:0] lbeg, lbeg_next;
  logic [8*KW_MAX-1:0]    iword, iword_next;
  logic [3:0]             ilen, ilen_next;
  logic [7:0]             held, held_next;

  logic                   acc;
  logic [7:0]             b;
  logic [OFFSET_BITS-1:0] psat, pdec;
  out_item_t [2:0]        tok;
  logic [1:0]             n;
  logic                   again;
  logic [6:0]             k;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [6:0] op_single(input logic [7:0] c);
    case (c)
      "+": return 7'd9;
      "-": return 7'd12;
      "*": return 7'd14;
      "/": return 7'd16;
      "%": return 7'd18;
      "!": return 7'd20;
      "=": return 7'd23;
      ">": return 7'd26;
      "<": return 7'd29;
      "&": return 7'd32;
      "|": return 7'd35;
      "^": return 7'd37;
      ".": return K_DOT;
      ":": return 7'd43;
      default: return 7'd0;
    endcase
  endfunction

  function automatic logic [6:0] op_pair(input logic [7:0] c, input logic [7:0] d);
    case (c)
      "+": return d == "=" ? 7'd8 : 7'd0;
      "-": return d == ">" ? 7'd10 : (d == "=" ? 7'd11 : 7'd0);
      "*": return d == "=" ? 7'd13 : 7'd0;
      "/": return d == "=" ? 7'd15 : 7'd0;
      "%": return d == "=" ? 7'd17 : 7'd0;
      "!": return d == "=" ? 7'd19 : 7'd0;
      "=": return d == "=" ? 7'd21 : (d == ">" ? 7'd22 : 7'd0);
      ">": return d == "=" ? 7'd24 : (d == ">" ? 7'd25 : 7'd0);
      "<": return d == "=" ? 7'd27 : (d == "<" ? 7'd28 : 7'd0);
      "&": return d == "&" ? 7'd30 : (d == "=" ? 7'd31 : 7'd0);
      "|": return d == "|" ? 7'd33 : (d == "=" ? 7'd34 : 7'd0);
      "^": return d == "=" ? 7'd36 : 7'd0;
      ".": return d == "." ? 7'd40 : 7'd0;
      ":": return d == ":" ? 7'd42 : 7'd0;
      default: return 7'd0;
    endcase
  endfunction

  function automatic logic [6:0] lone_kind(input logic [7:0] c);
    case (c)
      "(": return 7'd2;
      ")": return 7'd3;
      "[": return 7'd4;
      "]": return 7'd5;
      "{": return 7'd6;
      "}": return 7'd7;
      "~": return 7'd38;
      ",": return 7'd39;
      ";": return 7'd44;
      "?": return 7'd45;
      "@": return 7'd46;
      default: return 7'd0;
    endcase
  endfunction

  function automatic out_item_t mk(input logic [6:0] kd, input logic [OFFSET_BITS-1:0] s,
                                   input logic [OFFSET_BITS-1:0] e,
                                   input logic [LINE_BITS-1:0] lc,
                                   input logic [OFFSET_BITS-1:0] lb);
    out_item_t t;
    t.kind         = kd;
    t.tok_offset   = s;
    t.length       = 16'(e - s);
    t.line         = lc;
    t.column       = 16'(s - lb + OFFSET_BITS'(1));
    t.last         = 1'b0;
    return t;
  endfunction

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign b        = in_data.byte_req;
  assign psat     = (pos == OFF_MAX) ? pos : pos + OFFSET_BITS'(1);
  assign pdec     = (pos == '0) ? pos : pos - OFFSET_BITS'(1);

  always_comb begin
    mode_next   = mode;
    tstart_next = tstart;
    pos_next    = pos;
    lcnt_next   = lcnt;
    lbeg_next   = lbeg;
    iword_next  = iword;
    ilen_next   = ilen;
    held_next   = held;
    tok         = '0;
    n           = 2'd0;
    again       = 1'b0;
    k           = 7'd0;
    if (in_data.command) begin
      // flush pending token, then end token
      case (mode)
        M_IDENT: begin
          tok[n] = mk(word_kind(ilen, iword), tstart, pos, lcnt, lbeg);
          n = n + 2'd1;
        end
        M_NUM: begin
          tok[n] = mk(K_INT, tstart, pos, lcnt, lbeg);
          n = n + 2'd1;
        end
        M_NUM_DOT: begin
          tok[0] = mk(K_INT, tstart, pdec, lcnt, lbeg);
          tok[1] = mk(K_DOT, pdec, pos, lcnt, lbeg);
          n = 2'd2;
        end
        M_FRAC: begin
          tok[n] = mk(K_FLOAT, tstart, pos, lcnt, lbeg);
          n = n + 2'd1;
        end
        M_OP: begin
          tok[n] = mk(op_single(held), tstart, pos, lcnt, lbeg);
          n = n + 2'd1;
        end
        M_STR, M_CHAR0, M_CHAR1: begin
          tok[n] = mk(K_ERROR, tstart, pos, lcnt, lbeg);
          n = n + 2'd1;
        end
        default: ;
      endcase
      tok[n] = mk(K_END, pos, pos, lcnt, lbeg);
      n = n + 2'd1;
      mode_next   = M_IDLE;
      tstart_next = '0;
      pos_next    = '0;
      lcnt_next   = LINE_BITS'(1);
      lbeg_next   = '0;
      ilen_next   = 4'd0;
      held_next   = 8'd0;
    end else begin
      // a byte may be rescanned after the token it ends: at most three passes
      again = 1'b1;
      for (int pass = 0; pass < 3; pass++) begin
        if (again) begin
          again = 1'b0;
          case (mode_next)
            M_IDLE: begin
              tstart_next = pos;
              if (b == " " || b == 8'h09 || b == 8'h0D) begin
              end else if (b == 8'h0A) begin
                if (lcnt_next != LINE_MAX) lcnt_next = lcnt_next + LINE_BITS'(1);
                lbeg_next = psat;
              end else if (is_letter(b)) begin
                iword_next = {iword_next[8*KW_MAX-9:0], b};
                ilen_next  = 4'd1;
                mode_next  = M_IDENT;
              end else if (is_num(b)) begin
                mode_next = M_NUM;
              end else if (op_single(b) != 7'd0) begin
                held_next = b;
                mode_next = M_OP;
              end else if (b == 8'h22) begin
                mode_next = M_STR;
              end else if (b == 8'h27) begin
                mode_next = M_CHAR0;
              end else begin
                k = lone_kind(b);
                tok[n] = mk((k != 7'd0) ? k : K_ERROR, pos, psat, lcnt_next, lbeg_next);
                n = n + 2'd1;
              end
            end
            M_LINECOM: begin
              if (b == 8'h0A) begin
                mode_next = M_IDLE;
                again = 1'b1;
              end
            end
            M_BLOCK: begin
              if (b == 8'h0A) begin
                if (lcnt_next != LINE_MAX) lcnt_next = lcnt_next + LINE_BITS'(1);
                lbeg_next = psat;
              end else if (b == "*") begin
                mode_next = M_BLOCK_STAR;
              end
            end
            M_BLOCK_STAR: begin
              if (b == "/") begin
                mode_next = M_IDLE;
              end else if (b != "*") begin
                if (b == 8'h0A) begin
                  if (lcnt_next != LINE_MAX) lcnt_next = lcnt_next + LINE_BITS'(1);
                  lbeg_next = psat;
                end
                mode_next = M_BLOCK;
              end
            end
            M_IDENT: begin
              if (is_letter(b) || is_num(b)) begin
                if (ilen_next < 4'(KW_MAX)) iword_next = {iword_next[8*KW_MAX-9:0], b};
                if (ilen_next != 4'd15) ilen_next = ilen_next + 4'd1;
              end else begin
                tok[n] = mk(word_kind(ilen_next, iword_next), tstart_next, pos,
                            lcnt_next, lbeg_next);
                n = n + 2'd1;
                mode_next = M_IDLE;
                again = 1'b1;
              end
            end
            M_NUM: begin
              if (b == ".") begin
                mode_next = M_NUM_DOT;
              end else if (!is_num(b)) begin
                tok[n] = mk(K_INT, tstart_next, pos, lcnt_next, lbeg_next);
                n = n + 2'd1;
                mode_next = M_IDLE;
                again = 1'b1;
              end
            end
            M_NUM_DOT: begin
              if (is_num(b)) begin
                mode_next = M_FRAC;
              end else begin
                // integer, then the dot goes back through the operator path
                tok[n] = mk(K_INT, tstart_next, pdec, lcnt_next, lbeg_next);
                n = n + 2'd1;
                tstart_next = pdec;
                held_next   = ".";
                mode_next   = M_OP;
                again = 1'b1;
              end
            end
            M_FRAC: begin
              if (!is_num(b)) begin
                tok[n] = mk(K_FLOAT, tstart_next, pos, lcnt_next, lbeg_next);
                n = n + 2'd1;
                mode_next = M_IDLE;
                again = 1'b1;
              end
            end
            M_OP: begin
              if (held_next == "/" && b == "/") begin
                mode_next = M_LINECOM;
              end else if (held_next == "/" && b == "*") begin
                mode_next = M_BLOCK;
              end else begin
                k = op_pair(held_next, b);
                mode_next = M_IDLE;
                if (k != 7'd0) begin
                  tok[n] = mk(k, tstart_next, psat, lcnt_next, lbeg_next);
                end else begin
                  tok[n] = mk(op_single(held_next), tstart_next, pos, lcnt_next, lbeg_next);
                  again = 1'b1;
                end
                n = n + 2'd1;
              end
            end
            M_STR: begin
              if (b == 8'h22) begin
                tok[n] = mk(K_STRING, tstart_next, psat, lcnt_next, lbeg_next);
                n = n + 2'd1;
                mode_next = M_IDLE;
              end else if (b == 8'h0A) begin
                if (lcnt_next != LINE_MAX) lcnt_next = lcnt_next + LINE_BITS'(1);
                lbeg_next = psat;
              end
            end
            M_CHAR0: begin
              mode_next = M_CHAR1;
            end
            M_CHAR1: begin
              mode_next = M_IDLE;
              if (b == 8'h27) begin
                tok[n] = mk(K_CHAR, tstart_next, psat, lcnt_next, lbeg_next);
              end else begin
                tok[n] = mk(K_ERROR, tstart_next, pos, lcnt_next, lbeg_next);
                again = 1'b1;
              end
              n = n + 2'd1;
            end
            default: begin
              mode_next = M_IDLE;
              again = 1'b1;
            end
          endcase
        end
      end
      pos_next = psat;
    end
  end

  assign push            = acc && (n != 2'd0);
  assign push_data.count = n;
  assign push_data.tok   = tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      tstart <= '0;
      pos    <= '0;
      lcnt   <= LINE_BITS'(1);
      lbeg   <= '0;
      ilen   <= 4'd0;
      held   <= 8'd0;
    end else if (acc) begin
      mode   <= mode_next;
      tstart <= tstart_next;
      pos    <= pos_next;
      lcnt   <= lcnt_next;
      lbeg   <= lbeg_next;
      ilen   <= ilen_next;
      held   <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) iword <= iword_next;
  end

endmodule

FILE: rtl/stsc_queue.sv
module stsc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  stsc_pkg::bundle_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              nonempty,
  output stsc_pkg::bundle_t head
);
  import stsc_pkg::*;

  bundle_t    slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign head     = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

endmodule

FILE: rtl/stsc_back.sv
module stsc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               nonempty,
  input  stsc_pkg::bundle_t  head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output stsc_pkg::out_item_t out_data
);
  import stsc_pkg::*;

  logic [1:0] idx;
  logic       is_last;

  assign is_last   = (idx == head.count - 2'd1);
  assign out_valid = nonempty;
  always_comb begin
    out_data      = head.tok[idx];
    out_data.last = is_last;
  end
  assign pop = nonempty && !out_stall && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (nonempty && !out_stall) begin
      idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

FILE: rtl/source_token_scanner_unit.sv
// Source token scanner. Takes one source byte (or an end-of-source command) per cycle and
// delivers tokens one per cycle, each side unless stalled. An item that completes tokens
// hands all of them (at most three) to a two-entry queue in the same cycle; the output
// side drains them one per cycle, so an item that yields two or three tokens holds the
// input back only once the queue fills. End of source flushes the pending token, adds
// an end token and returns the scanner to its reset state. No clearing pass after reset.
module source_token_scanner_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  stsc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stsc_pkg::out_item_t out_data
);
  import stsc_pkg::*;

  logic    push, pop, full, nonempty;
  bundle_t push_data, head;

  stsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (full),
    .push      (push),
    .push_data (push_data)
  );

  stsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .nonempty  (nonempty),
    .head      (head)
  );

  stsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (nonempty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
